// ----- rtl/ppa_pkg.sv -----
// Shared types and constants for the particle pool allocator and step unit.
package ppa_pkg;

   // Pool geometry; the free-slot search looks at one 32-slot group per cycle
   localparam int SLOTS    = 512;
   localparam int IDX_W    = $clog2(SLOTS);
   localparam int GRP_BITS = 32;
   localparam int GRP_LSB  = $clog2(GRP_BITS);
   localparam int GROUPS   = SLOTS / GRP_BITS;
   localparam int GRP_W    = IDX_W - GRP_LSB;
   localparam int QDEPTH   = 2;

   // Opcodes of the request channel
   localparam logic OP_SPAWN = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   typedef enum logic [1:0] {
      CMD_SPAWN,
      CMD_STEP,
      CMD_SKIP
   } cmd_kind_type;

   // Classified request as it travels from the front queue to the back end
   typedef struct packed {
      cmd_kind_type       kind;
      logic [8:0]         slot;
      logic [15:0]        dt;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic [15:0]        alpha;
      logic [23:0]        fade_rate;
      logic [30:0]        life;
   } cmd_type;

   // Result beat
   typedef struct packed {
      logic [8:0]         out_slot;
      logic               alive;
      logic               evicted;
      logic signed [31:0] out_pos_x;
      logic signed [31:0] out_pos_y;
      logic signed [31:0] out_pos_z;
      logic [15:0]        out_alpha;
   } rsp_type;

endpackage

// ----- rtl/ppa_front.sv -----
// Front end: accepts request beats, classifies them and queues them for the back end.
module ppa_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_opcode,
   input  logic [8:0]           req_slot,
   input  logic [15:0]          req_dt,
   input  logic signed [31:0]   req_pos_x,
   input  logic signed [31:0]   req_pos_y,
   input  logic signed [31:0]   req_pos_z,
   input  logic signed [31:0]   req_vel_x,
   input  logic signed [31:0]   req_vel_y,
   input  logic signed [31:0]   req_vel_z,
   input  logic [15:0]          req_alpha,
   input  logic [23:0]          req_fade_rate,
   input  logic [30:0]          req_life,
   output logic                 cmd_valid,
   output ppa_pkg::cmd_type     cmd,
   input  logic                 cmd_take
);

   ppa_pkg::cmd_type                      qmem_ff [ppa_pkg::QDEPTH];
   logic [$clog2(ppa_pkg::QDEPTH)-1:0]    wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [$clog2(ppa_pkg::QDEPTH):0]      count_ff, count_in;
   ppa_pkg::cmd_type                      cls;
   logic                                  push;
   logic                                  pop;

   // Classify the incoming beat
   always_comb begin
      cls = '0;
      cls.slot      = req_slot;
      cls.dt        = req_dt;
      cls.pos_x     = req_pos_x;
      cls.pos_y     = req_pos_y;
      cls.pos_z     = req_pos_z;
      cls.vel_x     = req_vel_x;
      cls.vel_y     = req_vel_y;
      cls.vel_z     = req_vel_z;
      cls.alpha     = req_alpha;
      cls.fade_rate = req_fade_rate;
      cls.life      = req_life;
      if (req_opcode == ppa_pkg::OP_SPAWN) begin
         cls.kind = ppa_pkg::CMD_SPAWN;
      end else if (32'(req_slot) >= ppa_pkg::SLOTS) begin
         cls.kind = ppa_pkg::CMD_SKIP;
      end else begin
         cls.kind = ppa_pkg::CMD_STEP;
      end
   end

   assign req_stall = (count_ff == ($clog2(ppa_pkg::QDEPTH)+1)'(ppa_pkg::QDEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_valid && cmd_take;
   assign cmd       = qmem_ff[rptr_ff];

   // Advance queue pointers
   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + (($clog2(ppa_pkg::QDEPTH)+1)'(push))
                 - (($clog2(ppa_pkg::QDEPTH)+1)'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Hold queued beats
   always_ff @(posedge clock) begin
      if (push) begin
         qmem_ff[wptr_ff] <= cls;
      end
   end

endmodule

// ----- rtl/ppa_back.sv -----
// Back end: free-slot search, particle memory, step integrator and result register.
module ppa_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  ppa_pkg::cmd_type     cmd,
   output logic                 cmd_take,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ppa_pkg::rsp_type     rsp
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SPAWN_WR,
      S_RD,
      S_FIN,
      S_SKIP
   } state_type;

   typedef struct packed {
      logic signed [31:0] life;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic [15:0]        alpha;
      logic [23:0]        fade;
   } entry_type;

   localparam int IW = ppa_pkg::IDX_W;
   localparam int GW = ppa_pkg::GRP_W;
   localparam int LW = ppa_pkg::GRP_LSB;
   localparam int BW = ppa_pkg::GRP_BITS;

   state_type                 state_ff, state_in;
   ppa_pkg::cmd_type          cmd_ff, cmd_in;
   logic [GW:0]               cnt_ff, cnt_in;
   logic [IW-1:0]             idx_ff, idx_in;
   logic                      evict_ff, evict_in;
   logic [IW-1:0]             last_ff, last_in;
   logic [ppa_pkg::SLOTS-1:0] alive_ff, alive_in;
   logic signed [48:0]        prod_x_ff, prod_x_in;
   logic signed [48:0]        prod_y_ff, prod_y_in;
   logic signed [48:0]        prod_z_ff, prod_z_in;
   logic [39:0]               fprod_ff, fprod_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   ppa_pkg::rsp_type          rsp_ff, rsp_in;

   entry_type                 mem [ppa_pkg::SLOTS];
   entry_type                 rd_ff;
   logic                      mem_re;
   logic [IW-1:0]             mem_ra;
   logic                      mem_we;
   logic [IW-1:0]             mem_wa;
   entry_type                 mem_wd;

   logic                      out_free;
   logic [GW-1:0]             grp;
   logic [BW-1:0]             word;
   logic [BW-1:0]             mask;
   logic [BW-1:0]             freev;
   logic [BW-1:0]             lowest;
   logic [LW-1:0]             bitpos;
   logic [IW-1:0]             step_idx;
   logic signed [32:0]        life_diff;
   logic signed [31:0]        new_life;
   logic signed [31:0]        new_px, new_py, new_pz;
   logic [23:0]               dec;
   logic [15:0]               new_alpha;
   logic                      live;

   // Saturate a 34-bit difference to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -34'sh0_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Move a position back by floor(prod / 2^16)
   function automatic logic signed [31:0] move(input logic signed [31:0] p,
                                               input logic signed [48:0] prod);
      logic signed [32:0] mv;
      logic signed [33:0] d;
      mv = 33'(prod >>> 16);
      d  = {{2{p[31]}}, p} - {mv[32], mv};
      return sat32(d);
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign cmd_take  = (state_ff == S_IDLE) && cmd_valid;
   assign step_idx  = cmd_ff.slot[IW-1:0];

   // Look at one group of alive bits and pick the lowest free slot in it
   always_comb begin
      grp  = last_ff[IW-1:LW] + cnt_ff[GW-1:0];
      word = alive_ff[{grp, LW'(0)} +: BW];
      if (cnt_ff == '0) begin
         mask = ~((BW'(1) << last_ff[LW-1:0]) - BW'(1));
      end else if (cnt_ff == (GW+1)'(ppa_pkg::GROUPS)) begin
         mask = (BW'(1) << last_ff[LW-1:0]) - BW'(1);
      end else begin
         mask = '1;
      end
      freev  = ~word & mask;
      lowest = freev & (~freev + BW'(1));
      bitpos = '0;
      for (int i = 0; i < BW; i++) begin
         if (lowest[i]) begin
            bitpos = bitpos | LW'(i);
         end
      end
   end

   // Step arithmetic on the fetched entry and registered products
   always_comb begin
      life_diff = {rd_ff.life[31], rd_ff.life} - 33'(cmd_ff.dt);
      new_life  = sat32({life_diff[32], life_diff});
      live      = (new_life > 0);
      new_px    = move(rd_ff.pos_x, prod_x_ff);
      new_py    = move(rd_ff.pos_y, prod_y_ff);
      new_pz    = move(rd_ff.pos_z, prod_z_ff);
      dec       = fprod_ff[39:16];
      new_alpha = (dec >= 24'(rd_ff.alpha)) ? 16'd0 : rd_ff.alpha - dec[15:0];
   end

   // Sequence one command at a time
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      evict_in     = evict_ff;
      last_in      = last_ff;
      alive_in     = alive_ff;
      prod_x_in    = prod_x_ff;
      prod_y_in    = prod_y_ff;
      prod_z_in    = prod_z_ff;
      fprod_in     = fprod_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      mem_re       = 1'b0;
      mem_ra       = cmd.slot[IW-1:0];
      mem_we       = 1'b0;
      mem_wa       = idx_ff;
      mem_wd       = rd_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_in = cmd;
               cnt_in = '0;
               unique case (cmd.kind)
                  ppa_pkg::CMD_SPAWN: state_in = S_SCAN;
                  ppa_pkg::CMD_STEP: begin
                     mem_re   = 1'b1;
                     state_in = S_RD;
                  end
                  default: state_in = S_SKIP;
               endcase
            end
         end
         S_SCAN: begin
            if (freev != '0) begin
               idx_in   = {grp, bitpos};
               evict_in = 1'b0;
               state_in = S_SPAWN_WR;
            end else if (cnt_ff == (GW+1)'(ppa_pkg::GROUPS)) begin
               idx_in   = '0;
               evict_in = 1'b1;
               state_in = S_SPAWN_WR;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_SPAWN_WR: begin
            if (out_free) begin
               mem_we          = 1'b1;
               mem_wd.life     = {1'b0, cmd_ff.life};
               mem_wd.pos_x    = cmd_ff.pos_x;
               mem_wd.pos_y    = cmd_ff.pos_y;
               mem_wd.pos_z    = cmd_ff.pos_z;
               mem_wd.vel_x    = cmd_ff.vel_x;
               mem_wd.vel_y    = cmd_ff.vel_y;
               mem_wd.vel_z    = cmd_ff.vel_z;
               mem_wd.alpha    = cmd_ff.alpha;
               mem_wd.fade     = cmd_ff.fade_rate;
               alive_in[idx_ff] = (cmd_ff.life != '0);
               last_in         = idx_ff;
               rsp_valid_in    = 1'b1;
               rsp_in          = '0;
               rsp_in.out_slot = 9'(idx_ff);
               rsp_in.evicted  = evict_ff;
               state_in        = S_IDLE;
            end
         end
         S_RD: begin
            prod_x_in = rd_ff.vel_x * $signed({1'b0, cmd_ff.dt});
            prod_y_in = rd_ff.vel_y * $signed({1'b0, cmd_ff.dt});
            prod_z_in = rd_ff.vel_z * $signed({1'b0, cmd_ff.dt});
            fprod_in  = rd_ff.fade * cmd_ff.dt;
            state_in  = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in          = '0;
               rsp_in.out_slot = cmd_ff.slot;
               mem_wa          = step_idx;
               if (alive_ff[step_idx]) begin
                  mem_we         = 1'b1;
                  mem_wd.life    = new_life;
                  alive_in[step_idx] = live;
                  if (live) begin
                     mem_wd.pos_x     = new_px;
                     mem_wd.pos_y     = new_py;
                     mem_wd.pos_z     = new_pz;
                     mem_wd.alpha     = new_alpha;
                     rsp_in.alive     = 1'b1;
                     rsp_in.out_pos_x = new_px;
                     rsp_in.out_pos_y = new_py;
                     rsp_in.out_pos_z = new_pz;
                     rsp_in.out_alpha = new_alpha;
                  end
               end
               state_in = S_IDLE;
            end
         end
         S_SKIP: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in          = '0;
               rsp_in.out_slot = cmd_ff.slot;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         last_ff      <= '0;
         alive_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         alive_ff     <= alive_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff    <= cmd_in;
      cnt_ff    <= cnt_in;
      idx_ff    <= idx_in;
      evict_ff  <= evict_in;
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      prod_z_ff <= prod_z_in;
      fprod_ff  <= fprod_in;
      rsp_ff    <= rsp_in;
   end

   // Particle memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_ra];
      end
   end

endmodule

// ----- rtl/particle_pool_alloc_and_step_unit.sv -----
// Top level of the particle pool allocator and step unit.
//
// Request channel (req_*): opcode 0 spawns a particle into the first slot at or
// after the last used slot whose alive bit is clear; opcode 1 steps one slot
// by dt. Each request gives one result beat on the rsp_* channel, in order.
// A two-deep queue sits between the accepting front end and the back end, so
// requests keep being accepted while the back end works or the result stalls.
// The back end takes a queued beat whenever it is idle. A step then reads the
// memory, multiplies and writes back, and registers its result. A spawn
// searches the alive bits one 32-slot group per cycle (1 to 17 groups); if
// none is free it evicts slot 0. It then writes the slot and registers its
// result. Items are worked one at a time: no new beat is taken until the
// last one's result is registered.
// Reset clears the alive bits (every slot free), the last used slot and the
// queue at the next rising edge. While rsp_stall is high the result beat holds
// and the back end waits at its final step; the queue then fills and req_stall
// rises.
module particle_pool_alloc_and_step_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_opcode,
   input  logic [8:0]           req_slot,
   input  logic [15:0]          req_dt,
   input  logic signed [31:0]   req_pos_x,
   input  logic signed [31:0]   req_pos_y,
   input  logic signed [31:0]   req_pos_z,
   input  logic signed [31:0]   req_vel_x,
   input  logic signed [31:0]   req_vel_y,
   input  logic signed [31:0]   req_vel_z,
   input  logic [15:0]          req_alpha,
   input  logic [23:0]          req_fade_rate,
   input  logic [30:0]          req_life,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [8:0]           rsp_out_slot,
   output logic                 rsp_alive,
   output logic                 rsp_evicted,
   output logic signed [31:0]   rsp_out_pos_x,
   output logic signed [31:0]   rsp_out_pos_y,
   output logic signed [31:0]   rsp_out_pos_z,
   output logic [15:0]          rsp_out_alpha
);

   logic                 cmd_valid;
   logic                 cmd_take;
   ppa_pkg::cmd_type     cmd;
   ppa_pkg::rsp_type     rsp;

   ppa_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_slot      (req_slot),
      .req_dt        (req_dt),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_pos_z     (req_pos_z),
      .req_vel_x     (req_vel_x),
      .req_vel_y     (req_vel_y),
      .req_vel_z     (req_vel_z),
      .req_alpha     (req_alpha),
      .req_fade_rate (req_fade_rate),
      .req_life      (req_life),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_take      (cmd_take)
   );

   ppa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   // Unpack the result beat
   assign rsp_out_slot  = rsp.out_slot;
   assign rsp_alive     = rsp.alive;
   assign rsp_evicted   = rsp.evicted;
   assign rsp_out_pos_x = rsp.out_pos_x;
   assign rsp_out_pos_y = rsp.out_pos_y;
   assign rsp_out_pos_z = rsp.out_pos_z;
   assign rsp_out_alpha = rsp.out_alpha;

`ifndef SYNTHESIS
   // A result never reports both a live step and an eviction
   a_alive_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_alive && rsp_evicted))
      else $error("result flags both alive and evicted");

   // Results that are not alive carry zero position and opacity
   a_dead_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_alive) |-> (rsp_out_alpha == 16'd0 && rsp_out_pos_x == 32'sd0
         && rsp_out_pos_y == 32'sd0 && rsp_out_pos_z == 32'sd0))
      else $error("dead result carries nonzero payload");

   // No result beat right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule
